@@ src/date_validate_and_day_difference_top_macros.svh @@
// Assertion macros for the date validate and day difference block.
// Included by the RTL files that carry concurrent assertions.
`ifndef DATE_VALIDATE_AND_DAY_DIFFERENCE_TOP_MACROS_SVH
`define DATE_VALIDATE_AND_DAY_DIFFERENCE_TOP_MACROS_SVH

`ifndef SYNTH

`define DVD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
		else $error("dvd assertion failed");

`define DVD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
		else $error("dvd assertion failed");

`else

`define DVD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`define DVD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ src/dvd_pkg.sv @@
// Shared constants, types and calendar functions of the date difference block.
// No dependencies.
package dvd_pkg;

	localparam int YEAR_BITS_DEF = 14;
	localparam int YEAR_MAX_BITS = 16;
	localparam int CENT_BITS = 10;
	localparam int DAY_NUM_BITS = 25;
	localparam int DIFF_BITS = 22;
	localparam logic [DIFF_BITS-1:0] DIFF_MAX = '1;

	localparam int DIV100_SHIFT = 23;
	localparam logic [16:0] DIV100_MULT = 17'd83887;

	localparam int STATUS_TIME_BAD = 0;
	localparam int STATUS_DATE_BAD = 1;

	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_DEC = 4'd12;

	typedef struct packed {
		logic                    date_ok;
		logic [DAY_NUM_BITS-1:0] num;
	} dvd_day_t;

	function automatic logic [8:0] days_before(input logic [3:0] month);
		logic [8:0] d;
		case (month)
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		case (month)
			4'd2:                     len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
			default:                  len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

@@ src/dvd_day_num.sv @@
// Three-stage date check and day number unit: divide by 100, leap and
// validity with partial sums, final add. Depends on dvd_pkg.
module dvd_day_num
	import dvd_pkg::*;
#(
	parameter int YEAR_BITS = YEAR_BITS_DEF
) (
	input  logic                 clk,
	input  logic [YEAR_BITS-1:0] year,
	input  logic [3:0]           month,
	input  logic [4:0]           day,
	input  logic                 rec_ok,
	output dvd_day_t             res
);

	logic [YEAR_MAX_BITS-1:0] year_ext;
	logic [32:0]              prod100;
	logic [CENT_BITS-1:0]     cent_s1;
	logic [YEAR_MAX_BITS-1:0] year_s1;
	logic [3:0]               month_s1;
	logic [4:0]               day_s1;
	logic                     rec_ok_s1;

	logic [6:0]               rem_c;
	logic                     leap_c;
	logic                     date_ok_c;
	logic [14:0]              ceil4_c;
	logic [10:0]              ceil100_c;
	logic [8:0]               ceil400_c;
	logic [14:0]              leaps_c;
	logic [8:0]               offset_c;

	logic [DAY_NUM_BITS-1:0]  y365_s2;
	logic [14:0]              leaps_s2;
	logic [8:0]               offset_s2;
	logic                     date_ok_s2;
	logic                     rec_ok_s2;

	assign year_ext = YEAR_MAX_BITS'(year);
	assign prod100  = 33'(year_ext) * 33'(DIV100_MULT);

	always_ff @(posedge clk) begin
		cent_s1   <= prod100[DIV100_SHIFT +: CENT_BITS];
		year_s1   <= year_ext;
		month_s1  <= month;
		day_s1    <= day;
		rec_ok_s1 <= rec_ok;
	end

	always_comb begin
		rem_c     = 7'(year_s1 - YEAR_MAX_BITS'(cent_s1) * YEAR_MAX_BITS'(100));
		leap_c    = ((year_s1[1:0] == 2'd0) && (rem_c != 7'd0)) ||
		            ((rem_c == 7'd0) && (cent_s1[1:0] == 2'd0));
		date_ok_c = (month_s1 inside {[MONTH_JAN:MONTH_DEC]}) && (day_s1 != 5'd0) &&
		            (day_s1 <= month_len(month_s1, leap_c));
		ceil4_c   = 15'((17'(year_s1) + 17'd3) >> 2);
		ceil100_c = 11'(cent_s1) + 11'(rem_c != 7'd0);
		ceil400_c = 9'(cent_s1 >> 2) + 9'((rem_c != 7'd0) || (cent_s1[1:0] != 2'd0));
		leaps_c   = ceil4_c - 15'(ceil100_c) + 15'(ceil400_c);
		offset_c  = days_before(month_s1) + 9'(day_s1) +
		            9'((month_s1 > MONTH_FEB) && leap_c);
	end

	always_ff @(posedge clk) begin
		y365_s2    <= DAY_NUM_BITS'(year_s1) * DAY_NUM_BITS'(365);
		leaps_s2   <= leaps_c;
		offset_s2  <= offset_c;
		date_ok_s2 <= date_ok_c;
		rec_ok_s2  <= rec_ok_s1;
	end

	always_ff @(posedge clk) begin
		res.date_ok <= date_ok_s2;
		res.num     <= (date_ok_s2 && rec_ok_s2) ?
		               (y365_s2 + DAY_NUM_BITS'(leaps_s2) + DAY_NUM_BITS'(offset_s2)) : '0;
	end

endmodule

@@ src/date_validate_and_day_difference_top.sv @@
// Top level of the date validate and day difference block.
// Depends on dvd_pkg, dvd_day_num and the assertion macro header.
//
// Usage: a request is taken at a rising clock edge where start is high and
// busy is low. It carries a first date with a time of day and a second date.
// Busy is always low, so a new request may follow in every cycle.
// After a request is taken, done is high for exactly one cycle
// with first_status (bit 0 bad time, bit 1 bad date), second_ok and
// day_difference, the absolute difference of the two day numbers counted
// from year 0. A bad first record or a bad second date counts as day 0.
// Throughput is one request per cycle. A request passes through the registered
// divide by 100, multiply by 365, day number add and difference stages.
// The receiver cannot stall, so results are never held back.
// Reset clears the stage valid bits; no result appears until a request
// is taken after reset.
`include "date_validate_and_day_difference_top_macros.svh"

module date_validate_and_day_difference_top
	import dvd_pkg::*;
#(
	parameter int YEAR_BITS = YEAR_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [YEAR_BITS-1:0] first_year,
	input  logic [3:0]           first_month,
	input  logic [4:0]           first_day,
	input  logic [4:0]           first_hour,
	input  logic [5:0]           first_minute,
	input  logic [5:0]           first_second,
	input  logic [YEAR_BITS-1:0] second_year,
	input  logic [3:0]           second_month,
	input  logic [4:0]           second_day,
	output logic                 done,
	output logic [1:0]           first_status,
	output logic                 second_ok,
	output logic [DIFF_BITS-1:0] day_difference
);

	logic                    time_ok_c;
	logic                    v_s1, v_s2, v_s3;
	logic                    tbad_s1, tbad_s2, tbad_s3;
	dvd_day_t                first_res;
	dvd_day_t                second_res;
	logic [DAY_NUM_BITS-1:0] diff_c;

	assign busy      = 1'b0;
	assign time_ok_c = (first_hour < 5'd24) && (first_minute < 6'd60) &&
	                   (first_second < 6'd60);

	dvd_day_num #(.YEAR_BITS(YEAR_BITS)) u_first (
		.clk    (clk),
		.year   (first_year),
		.month  (first_month),
		.day    (first_day),
		.rec_ok (time_ok_c),
		.res    (first_res)
	);

	dvd_day_num #(.YEAR_BITS(YEAR_BITS)) u_second (
		.clk    (clk),
		.year   (second_year),
		.month  (second_month),
		.day    (second_day),
		.rec_ok (1'b1),
		.res    (second_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			done <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		tbad_s1 <= !time_ok_c;
		tbad_s2 <= tbad_s1;
		tbad_s3 <= tbad_s2;
	end

	assign diff_c = (first_res.num > second_res.num) ?
	                (first_res.num - second_res.num) : (second_res.num - first_res.num);

	always_ff @(posedge clk) begin
		first_status[STATUS_TIME_BAD] <= tbad_s3;
		first_status[STATUS_DATE_BAD] <= !first_res.date_ok;
		second_ok                     <= second_res.date_ok;
		day_difference                <= (diff_c > DAY_NUM_BITS'(DIFF_MAX)) ?
		                                 DIFF_MAX : DIFF_BITS'(diff_c);
	end

	`DVD_ASSERT_IMPLY(a_latency, clk, arst_n, start && !busy, ##4 done)
	`DVD_ASSERT_IMPLY(a_no_spurious, clk, arst_n, !(start && !busy), ##4 !done)
	`DVD_ASSERT_IMPLY(a_both_bad_zero, clk, arst_n, done && !second_ok && (first_status != 2'b00), day_difference == '0)
	`DVD_ASSERT_NEXT(a_dates_bad_zero, clk, arst_n, v_s3 && !first_res.date_ok && !second_res.date_ok, day_difference == '0)

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for date_validate_and_day_difference_top: directed and random requests.
// It predicts the day difference and the status bits itself and checks each result strobe.
// Depends on dvd_pkg and the block's RTL.

import dvd_pkg::*;

typedef struct {
	logic [YEAR_BITS_DEF-1:0] y1;
	logic [3:0]               m1;
	logic [4:0]               d1;
	logic [4:0]               hh;
	logic [5:0]               mi;
	logic [5:0]               ss;
	logic [YEAR_BITS_DEF-1:0] y2;
	logic [3:0]               m2;
	logic [4:0]               d2;
} date_pair_t;

typedef struct {
	logic [1:0]           status;
	logic                 ok2;
	logic [DIFF_BITS-1:0] gap;
} gap_result_t;

class date_gap_board;
	gap_result_t expected_gaps[$];
	int errors;
	int n_requests;
	int n_results;
	int n_bad_first;
	int n_bad_second;
	int n_saturated;

	static function bit leap_year(int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	static function int unsigned month_days(int unsigned y, int unsigned m);
		if (m == MONTH_FEB) begin
			return leap_year(y) ? 29 : 28;
		end
		case (m)
			4, 6, 9, 11: return 30;
			default:     return 31;
		endcase
	endfunction

	static function bit date_legal(int unsigned y, int unsigned m, int unsigned d);
		if (m < MONTH_JAN || m > MONTH_DEC || d < 1) begin
			return 0;
		end
		return d <= month_days(y, m);
	endfunction

	// Days from year 0 up to and including the given date; 0000-01-01 is day 1.
	static function int unsigned day_count(int unsigned y, int unsigned m, int unsigned d);
		int unsigned n;
		n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400 + d;
		for (int unsigned k = MONTH_JAN; k < m; k++) begin
			n += month_days(y, k);
		end
		return n;
	endfunction

	function gap_result_t predict_gap(date_pair_t p);
		gap_result_t r;
		bit time_ok;
		bit first_ok;
		bit second_ok;
		int unsigned n1;
		int unsigned n2;
		int unsigned diff;
		time_ok = p.hh < 24 && p.mi < 60 && p.ss < 60;
		first_ok = date_legal(p.y1, p.m1, p.d1);
		second_ok = date_legal(p.y2, p.m2, p.d2);
		n1 = (first_ok && time_ok) ? day_count(p.y1, p.m1, p.d1) : 0;
		n2 = second_ok ? day_count(p.y2, p.m2, p.d2) : 0;
		diff = (n1 > n2) ? n1 - n2 : n2 - n1;
		if (diff > 32'(DIFF_MAX)) begin
			diff = 32'(DIFF_MAX);
			n_saturated++;
		end
		if (!(first_ok && time_ok)) n_bad_first++;
		if (!second_ok) n_bad_second++;
		r.status = '0;
		r.status[STATUS_TIME_BAD] = !time_ok;
		r.status[STATUS_DATE_BAD] = !first_ok;
		r.ok2 = second_ok;
		r.gap = diff[DIFF_BITS-1:0];
		return r;
	endfunction

	function void note_request(date_pair_t p);
		n_requests++;
		expected_gaps.push_back(predict_gap(p));
	endfunction

	function void check_result(gap_result_t got);
		gap_result_t want;
		n_results++;
		if (expected_gaps.size() == 0) begin
			errors++;
			if (errors <= 10) begin
				$display("ERROR: result with no request pending: status=%0d ok=%0d diff=%0d",
					got.status, got.ok2, got.gap);
			end
			return;
		end
		want = expected_gaps.pop_front();
		if (got.status !== want.status || got.ok2 !== want.ok2 || got.gap !== want.gap) begin
			errors++;
			if (errors <= 10) begin
				$display("ERROR: result %0d: expected status=%0d ok=%0d diff=%0d,",
					n_results, want.status, want.ok2, want.gap);
				$display("       got status=%0d ok=%0d diff=%0d",
					got.status, got.ok2, got.gap);
			end
		end
	endfunction

	function int pending();
		return expected_gaps.size();
	endfunction
endclass

module testbench;
	localparam int QUIET_LIMIT = 1000;
	localparam int PHASE_ITEMS = 225;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	logic [1:0] first_status;
	logic second_ok;
	logic [DIFF_BITS-1:0] day_difference;
	date_pair_t req;
	date_gap_board board = new();
	int quiet_cycles;

	date_validate_and_day_difference_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.first_year(req.y1),
		.first_month(req.m1),
		.first_day(req.d1),
		.first_hour(req.hh),
		.first_minute(req.mi),
		.first_second(req.ss),
		.second_year(req.y2),
		.second_month(req.m2),
		.second_day(req.d2),
		.done(done),
		.first_status(first_status),
		.second_ok(second_ok),
		.day_difference(day_difference)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		gap_result_t got;
		if (arst_n) begin
			if (start && !busy) begin
				board.note_request(req);
			end
			if (done) begin
				got.status = first_status;
				got.ok2 = second_ok;
				got.gap = day_difference;
				board.check_result(got);
			end
			if ((start && !busy) || done) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("ERROR: no request or result for %0d cycles", QUIET_LIMIT);
				$display("simulation failed");
				$finish;
			end
		end
	end

	task automatic send(date_pair_t p);
		start <= 1'b1;
		req <= p;
		do @(posedge clk); while (busy);
	endtask

	task automatic send_fields(int y1, int m1, int d1, int hh, int mi, int ss,
		int y2, int m2, int d2);
		date_pair_t p;
		p.y1 = y1[YEAR_BITS_DEF-1:0];
		p.m1 = m1[3:0];
		p.d1 = d1[4:0];
		p.hh = hh[4:0];
		p.mi = mi[5:0];
		p.ss = ss[5:0];
		p.y2 = y2[YEAR_BITS_DEF-1:0];
		p.m2 = m2[3:0];
		p.d2 = d2[4:0];
		send(p);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
	endtask

	function automatic int unsigned random_year();
		if ($urandom_range(9) == 0) begin
			return $urandom_range(2 ** YEAR_BITS_DEF - 1);
		end
		return $urandom_range(9999);
	endfunction

	// Mostly well-formed dates with a valid time; the rest have fields replaced by raw noise.
	function automatic date_pair_t random_pair();
		date_pair_t p;
		int unsigned y;
		int unsigned m;
		bit noisy;
		y = random_year();
		m = $urandom_range(MONTH_DEC, MONTH_JAN);
		p.y1 = y[YEAR_BITS_DEF-1:0];
		p.m1 = m[3:0];
		p.d1 = 5'($urandom_range(board.month_days(y, m), 1));
		p.hh = 5'($urandom_range(23));
		p.mi = 6'($urandom_range(59));
		p.ss = 6'($urandom_range(59));
		if ($urandom_range(3) == 0) begin
			y = p.y1 + $urandom_range(2);
			y = y % (2 ** YEAR_BITS_DEF);
		end else begin
			y = random_year();
		end
		m = $urandom_range(MONTH_DEC, MONTH_JAN);
		p.y2 = y[YEAR_BITS_DEF-1:0];
		p.m2 = m[3:0];
		p.d2 = 5'($urandom_range(board.month_days(y, m), 1));
		noisy = $urandom_range(99) < 20;
		if (noisy) begin
			if ($urandom_range(1)) p.y1 = YEAR_BITS_DEF'($urandom);
			if ($urandom_range(1)) p.m1 = 4'($urandom);
			if ($urandom_range(1)) p.d1 = 5'($urandom);
			if ($urandom_range(1)) p.hh = 5'($urandom);
			if ($urandom_range(1)) p.mi = 6'($urandom);
			if ($urandom_range(1)) p.ss = 6'($urandom);
			if ($urandom_range(1)) p.y2 = YEAR_BITS_DEF'($urandom);
			if ($urandom_range(1)) p.m2 = 4'($urandom);
			if ($urandom_range(1)) p.d2 = 5'($urandom);
		end
		return p;
	endfunction

	initial begin
		int idle_pct [4];
		arst_n = 1'b0;
		start = 1'b0;
		req = '{default: '0};
		quiet_cycles = 0;
		idle_pct = '{0, 60, 35, 0};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_fields(0, 1, 1, 0, 0, 0, 0, 1, 1);
		send_fields(0, 2, 29, 12, 30, 30, 1, 1, 1);
		send_fields(1900, 2, 29, 0, 0, 0, 2000, 2, 29);
		send_fields(2000, 2, 29, 23, 59, 59, 2100, 2, 28);
		send_fields(2100, 2, 29, 0, 0, 0, 2004, 2, 29);
		send_fields(9999, 12, 31, 23, 59, 59, 0, 1, 1);
		send_fields(0, 1, 1, 0, 0, 0, 9999, 12, 31);
		send_fields(16383, 12, 31, 0, 0, 0, 0, 0, 0);
		send_fields(16383, 1, 1, 0, 0, 0, 0, 1, 1);
		send_fields(16000, 2, 29, 1, 2, 3, 16000, 3, 1);
		send_fields(2024, 1, 31, 24, 0, 0, 2024, 3, 1);
		send_fields(2024, 4, 30, 0, 60, 0, 2024, 5, 1);
		send_fields(2024, 6, 15, 0, 0, 60, 2024, 6, 16);
		send_fields(2024, 6, 15, 31, 63, 63, 2024, 6, 15);
		send_fields(2024, 0, 10, 0, 0, 0, 2024, 1, 10);
		send_fields(2024, 13, 1, 0, 0, 0, 2024, 12, 1);
		send_fields(2024, 15, 31, 0, 0, 0, 2023, 12, 31);
		send_fields(2024, 4, 31, 25, 0, 0, 2024, 4, 30);
		send_fields(2024, 7, 0, 0, 0, 0, 2024, 7, 1);
		send_fields(2024, 12, 31, 0, 0, 0, 2024, 11, 31);
		send_fields(2024, 9, 30, 0, 0, 0, 2024, 15, 31);
		send_fields(1999, 12, 31, 23, 59, 59, 2000, 1, 1);
		send_fields(2023, 3, 1, 0, 0, 0, 2023, 2, 28);
		drain();

		foreach (idle_pct[ph]) begin
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i == PHASE_ITEMS / 2 && ph == 1) begin
					drain();
				end
				if ($urandom_range(99) < idle_pct[ph]) begin
					start <= 1'b0;
					@(posedge clk);
					while ($urandom_range(99) < idle_pct[ph]) @(posedge clk);
				end
				send(random_pair());
			end
			drain();
		end

		repeat (8) @(posedge clk);
		$display("Run covered %0d requests and %0d results over 4 sender idle phases.",
			board.n_requests, board.n_results);
		$display("Bad first records: %0d, bad second dates: %0d, saturated differences: %0d.",
			board.n_bad_first, board.n_bad_second, board.n_saturated);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("simulation ok");
		end else begin
			$display("Mismatches: %0d, results still expected: %0d", board.errors,
				board.pending());
			$display("simulation failed");
		end
		$finish;
	end
endmodule

@@ files.f @@
+incdir+src
src/dvd_pkg.sv
src/dvd_day_num.sv
src/date_validate_and_day_difference_top.sv
tb/sv/testbench.sv
